FILE: hw/rtl/task_queue_fifo_sjf_ljf_defines.svh
// assertion helpers shared by the rtl
`ifndef TASK_QUEUE_FIFO_SJF_LJF_DEFINES_SVH
`define TASK_QUEUE_FIFO_SJF_LJF_DEFINES_SVH

// checked on every clock edge outside reset
`define TQ_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked on every clock edge, reset included
`define TQ_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

FILE: hw/rtl/tqsched_pkg.sv
package tqsched_pkg;

   // default number of task slots
   localparam int QUEUE_DEPTH_DEF = 16;

   // payload widths
   localparam int ID_W   = 8;
   localparam int PRIO_W = 8;
   localparam int TIME_W = 16;
   localparam int OCC_W  = 5;
   localparam int STAT_W = 2;
   localparam int POL_W  = 2;

   // request kinds
   localparam logic FUNC_ENQ = 1'b0;
   localparam logic FUNC_DEQ = 1'b1;

   // dequeue policy codes, the unused code behaves as oldest first
   localparam logic [POL_W-1:0] POL_OLDEST   = 2'd0;
   localparam logic [POL_W-1:0] POL_SHORTEST = 2'd1;
   localparam logic [POL_W-1:0] POL_LONGEST  = 2'd2;

   // response status codes
   typedef enum logic [STAT_W-1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   // one stored task
   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [PRIO_W-1:0] prio;
      logic [TIME_W-1:0] runtime;
   } task_type;

endpackage

FILE: hw/rtl/tqsched_req_if.sv
// request channel: enqueue or dequeue beats
interface tqsched_req_if import tqsched_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              func;
   logic [ID_W-1:0]   task_id;
   logic [PRIO_W-1:0] task_priority;
   logic [TIME_W-1:0] task_time;

   modport source (output valid, output func, output task_id, output task_priority,
                   output task_time, input ready);
   modport sink   (input valid, input func, input task_id, input task_priority,
                   input task_time, output ready);
endinterface

FILE: hw/rtl/tqsched_rsp_if.sv
// response channel: one beat per request
interface tqsched_rsp_if import tqsched_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [STAT_W-1:0] status;
   logic [ID_W-1:0]   out_id;
   logic [PRIO_W-1:0] out_priority;
   logic [TIME_W-1:0] out_time;
   logic [OCC_W-1:0]  occupancy;

   modport source (output valid, output status, output out_id, output out_priority,
                   output out_time, output occupancy, input ready);
   modport sink   (input valid, input status, input out_id, input out_priority,
                   input out_time, input occupancy, output ready);
endinterface

FILE: hw/rtl/task_queue_fifo_sjf_ljf.sv
// enqueue: the beat goes to S_DONE, which loads the response when the output register is free
// time-ordered dequeue of n held tasks: a scan of all n slots, one entry per cycle, then
//   the compaction sweep of the slots above the removed slot, then S_DONE loads the response
// oldest-first dequeue reads slot 0 only, then sweeps n-1 entries down
// next request taken in the same cycle the response goes valid; a full output register holds it off
// synchronous active-high reset empties the queue and selects oldest first
`include "task_queue_fifo_sjf_ljf_defines.svh"

module task_queue_fifo_sjf_ljf import tqsched_pkg::*; #(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_we,
   input  logic [POL_W-1:0] csr_wdata,
   tqsched_req_if.sink      req,
   tqsched_rsp_if.source    rsp
);

   localparam int IDX_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_SCAN_END,
      S_SHIFT,
      S_SHIFT_END,
      S_DONE
   } state_type;

   // control and result registers
   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  fill_ff, fill_in;
   logic [POL_W-1:0]  policy_ff, policy_in;
   logic [IDX_W-1:0]  addr_ff, addr_in;
   logic [IDX_W-1:0]  last_ff, last_in;
   logic [IDX_W-1:0]  cmp_idx_ff, cmp_idx_in;
   logic              data_vld_ff, data_vld_in;
   task_type          best_ff, best_in;
   logic [IDX_W-1:0]  best_idx_ff, best_idx_in;
   status_type        pend_status_ff, pend_status_in;
   logic              pend_func_ff, pend_func_in;
   logic              rsp_valid_ff, rsp_valid_in;
   status_type        rsp_status_ff, rsp_status_in;
   task_type          rsp_task_ff, rsp_task_in;
   logic [OCC_W-1:0]  rsp_occ_ff, rsp_occ_in;

   // task store
   task_type          mem [QUEUE_DEPTH];
   task_type          rd_data_ff;
   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   task_type          wr_data;

   logic              accept;
   logic              full;
   logic              issuing;
   logic              scanning;
   logic              shifting;
   logic              by_time;
   logic [TIME_W-1:0] cmp_a;
   logic [TIME_W-1:0] cmp_b;
   logic              better;
   logic              take;
   logic [IDX_W-1:0]  last_slot;

   assign req.ready = (state_ff == S_IDLE);
   assign accept    = req.valid && req.ready;
   assign full      = (fill_ff == CNT_W'(QUEUE_DEPTH));
   assign issuing   = state_ff inside {S_SCAN, S_SHIFT};
   assign scanning  = state_ff inside {S_SCAN, S_SCAN_END};
   assign shifting  = state_ff inside {S_SHIFT, S_SHIFT_END};
   assign by_time   = policy_ff inside {POL_SHORTEST, POL_LONGEST};
   assign last_slot = IDX_W'(fill_ff - 1'b1);

   // memory write port: enqueue at the request beat, else compaction
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = IDX_W'(fill_ff);
      wr_data = rd_data_ff;
      if (accept && req.func == FUNC_ENQ && !full) begin
         wr_en   = 1'b1;
         wr_data = '{id: req.task_id, prio: req.task_priority, runtime: req.task_time};
      end else if (shifting && data_vld_ff) begin
         wr_en   = 1'b1;
         wr_addr = IDX_W'(cmp_idx_ff - 1'b1);
      end
   end

   // memory with registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[addr_ff];
   end

   // shared comparator, operands swapped for longest first
   always_comb begin
      if (policy_ff == POL_LONGEST) begin
         cmp_a = best_ff.runtime;
         cmp_b = rd_data_ff.runtime;
      end else begin
         cmp_a = rd_data_ff.runtime;
         cmp_b = best_ff.runtime;
      end
      better = (cmp_a < cmp_b);
      take   = scanning && data_vld_ff && ((cmp_idx_ff == '0) || better);
   end

   // sequencer
   always_comb begin
      state_in       = state_ff;
      fill_in        = fill_ff;
      policy_in      = csr_we ? csr_wdata : policy_ff;
      addr_in        = addr_ff;
      last_in        = last_ff;
      cmp_idx_in     = addr_ff;
      data_vld_in    = issuing;
      best_in        = take ? rd_data_ff : best_ff;
      best_idx_in    = take ? cmp_idx_ff : best_idx_ff;
      pend_status_in = pend_status_ff;
      pend_func_in   = pend_func_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp.ready;
      rsp_status_in  = rsp_status_ff;
      rsp_task_in    = rsp_task_ff;
      rsp_occ_in     = rsp_occ_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               pend_func_in = req.func;
               if (req.func == FUNC_ENQ) begin
                  pend_status_in = full ? ST_FULL : ST_OK;
                  state_in       = S_DONE;
               end else if (fill_ff == '0) begin
                  pend_status_in = ST_EMPTY;
                  state_in       = S_DONE;
               end else begin
                  pend_status_in = ST_OK;
                  addr_in        = '0;
                  last_in        = by_time ? last_slot : '0;
                  state_in       = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (addr_ff == last_ff) begin
               state_in = S_SCAN_END;
            end else begin
               addr_in = IDX_W'(addr_ff + 1'b1);
            end
         end
         S_SCAN_END: begin
            // winner known now, compact the slots above it
            if (best_idx_in == last_slot) begin
               state_in = S_DONE;
            end else begin
               addr_in  = IDX_W'(best_idx_in + 1'b1);
               last_in  = last_slot;
               state_in = S_SHIFT;
            end
         end
         S_SHIFT: begin
            if (addr_ff == last_ff) begin
               state_in = S_SHIFT_END;
            end else begin
               addr_in = IDX_W'(addr_ff + 1'b1);
            end
         end
         S_SHIFT_END: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp.ready) begin
               if (pend_status_ff == ST_OK) begin
                  fill_in = (pend_func_ff == FUNC_ENQ) ? CNT_W'(fill_ff + 1'b1)
                                                       : CNT_W'(fill_ff - 1'b1);
               end
               rsp_valid_in  = 1'b1;
               rsp_status_in = pend_status_ff;
               rsp_task_in   = (pend_func_ff == FUNC_DEQ && pend_status_ff == ST_OK)
                               ? best_ff : '0;
               rsp_occ_in    = OCC_W'(fill_in);
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fill_ff      <= '0;
         policy_ff    <= POL_OLDEST;
         data_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         policy_ff    <= policy_in;
         data_vld_ff  <= data_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      addr_ff        <= addr_in;
      last_ff        <= last_in;
      cmp_idx_ff     <= cmp_idx_in;
      best_ff        <= best_in;
      best_idx_ff    <= best_idx_in;
      pend_status_ff <= pend_status_in;
      pend_func_ff   <= pend_func_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_task_ff    <= rsp_task_in;
      rsp_occ_ff     <= rsp_occ_in;
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.status       = rsp_status_ff;
   assign rsp.out_id       = rsp_task_ff.id;
   assign rsp.out_priority = rsp_task_ff.prio;
   assign rsp.out_time     = rsp_task_ff.runtime;
   assign rsp.occupancy    = rsp_occ_ff;

   // checks
   `TQ_ASSERT_ALWAYS(a_reset_empties, reset |=> (fill_ff == '0 && !rsp.valid), "queue not empty after reset")
   `TQ_ASSERT(a_fill_bound, fill_ff <= CNT_W'(QUEUE_DEPTH), "fill count beyond depth")
   `TQ_ASSERT(a_write_in_range, wr_en |-> (CNT_W'(wr_addr) <= fill_ff), "write above held tasks")
   `TQ_ASSERT(a_busy_after_beat, accept |=> !req.ready, "request taken while busy")
   `TQ_ASSERT(a_shift_in_range, shifting |-> (fill_ff != '0), "compaction on empty queue")

endmodule
